// ----- rtl/u8u16_pkg.sv -----
// Shared types, codes and helper functions for the UTF-8 to UTF-16 transcoder.
// No dependencies; every file of the block but the two channel interfaces imports this package.
package u8u16_pkg;

	localparam int unsigned UnitW = 16;
	localparam int unsigned ByteW = 8;
	localparam int unsigned CpW   = 21;
	localparam logic [UnitW-1:0] ReplacementReset = 16'h003F;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PAIR
	} u8u16_state_t;

	// What the datapath will do on a scan step at the current position.
	typedef enum logic [1:0] {
		SCAN_UNIT,
		SCAN_PAIR,
		SCAN_DONE
	} u8u16_scan_kind_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic pair_lo;
	} u8u16_cmd_t;

	typedef struct packed {
		u8u16_scan_kind_t kind;
		logic             hold_valid;
		logic             out_free;
	} u8u16_status_t;

	// Sequence length implied by a lead byte, or zero when it cannot lead.
	function automatic logic [2:0] lead_length(input logic [ByteW-1:0] b);
		logic [2:0] len;
		priority if (b[7] == 1'b0) begin
			len = 3'd1;
		end else if (b[7:6] == 2'b10) begin
			len = 3'd0;
		end else if (b[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (b[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (b[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

endpackage

// ----- rtl/u8u16_in_if.sv -----
// Byte channel of the transcoder: valid/ready handshake with one UTF-8 byte per beat.
// Depends on nothing but the standard logic type.
interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, in_byte, end_of_string, input ready);
	modport sink (input valid, in_byte, end_of_string, output ready);
endinterface

// ----- rtl/u8u16_out_if.sv -----
// Code unit channel of the transcoder: valid/ready handshake, one UTF-16 unit per beat.
// Depends on nothing but the standard logic type.
interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        run_last;
	logic        string_last;

	modport source (output valid, code_unit, run_last, string_last, input ready);
	modport sink (input valid, code_unit, run_last, string_last, output ready);
endinterface

// ----- rtl/u8u16_dp.sv -----
// Transcoder datapath: byte buffer, scan decoder, held unit and output register.
// Depends on u8u16_pkg; driven by commands from u8u16_ctrl.
module u8u16_dp
	import u8u16_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  u8u16_cmd_t           cmd,
	output u8u16_status_t        status,
	input  logic [ByteW-1:0]     in_byte,
	input  logic                 end_of_string,
	input  logic                 cfg_we,
	input  logic [UnitW-1:0]     cfg_wdata,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [UnitW-1:0]     code_unit,
	output logic                 run_last,
	output logic                 string_last
);

	logic [ByteW-1:0] pend_q [4];
	logic [2:0]       n_q;
	logic [2:0]       pos_q;
	logic             end_q;
	logic             hold_valid_q;
	logic [UnitW-1:0] hold_q;
	logic [UnitW-1:0] lo_q;
	logic [UnitW-1:0] rep_q;
	logic             out_valid_q;
	logic [UnitW-1:0] code_q;
	logic             run_last_q;
	logic             string_last_q;

	logic [ByteW-1:0] lead, b1, b2, b3;
	logic [2:0]       need, left, avail, adv;
	logic             bad;
	logic [CpW-1:0]   cp2, cp3, cp4;
	logic [19:0]      v;
	logic [UnitW-1:0] unit, lo_unit;
	u8u16_scan_kind_t kind;
	logic             push, push_last;

	assign lead = pend_q[pos_q[1:0]];
	assign b1   = pend_q[pos_q[1:0] + 2'd1];
	assign b2   = pend_q[pos_q[1:0] + 2'd2];
	assign b3   = pend_q[pos_q[1:0] + 2'd3];
	assign need = lead_length(lead);
	assign left = n_q - pos_q;
	assign avail = (left < need) ? left : need;

	always_comb begin
		bad = 1'b0;
		for (int k = 1; k < 4; k++) begin
			if ((3'(k) < avail) && (pend_q[pos_q[1:0] + 2'(k)][7:6] != 2'b10)) begin
				bad = 1'b1;
			end
		end
	end

	assign cp2 = {10'd0, lead[4:0], b1[5:0]};
	assign cp3 = {5'd0, lead[3:0], b1[5:0], b2[5:0]};
	assign cp4 = {lead[2:0], b1[5:0], b2[5:0], b3[5:0]};
	// Only reached for code points 0x10000..0x10FFFF, so the plane field is at least one.
	assign v = {cp4[19:16] - 4'd1, cp4[15:0]};
	assign lo_unit = {6'b110111, v[9:0]};

	always_comb begin
		kind = SCAN_UNIT;
		unit = rep_q;
		adv  = 3'd1;
		priority if (pos_q >= n_q) begin
			kind = SCAN_DONE;
		end else if (need == 3'd0) begin
			unit = rep_q;
		end else if (need == 3'd1) begin
			unit = {8'd0, lead};
		end else if (bad) begin
			unit = rep_q;
		end else if (avail < need) begin
			// An open sequence waits for more bytes unless the string ends here.
			if (!end_q) begin
				kind = SCAN_DONE;
			end
		end else if (need == 3'd2) begin
			unit = cp2[UnitW-1:0];
			adv  = 3'd2;
		end else if (need == 3'd3) begin
			unit = cp3[UnitW-1:0];
			adv  = 3'd3;
		end else begin
			adv = 3'd4;
			priority if (cp4[20:16] > 5'h10) begin
				unit = rep_q;
			end else if (cp4[20:16] != 5'h00) begin
				kind = SCAN_PAIR;
				unit = {6'b110110, v[19:10]};
			end else begin
				unit = cp4[UnitW-1:0];
			end
		end
	end

	assign push      = (cmd.scan_step || cmd.pair_lo) && hold_valid_q;
	assign push_last = cmd.scan_step && (kind == SCAN_DONE);

	assign status.kind       = kind;
	assign status.hold_valid = hold_valid_q;
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q          <= '0;
			pos_q        <= '0;
			end_q        <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			rep_q        <= ReplacementReset;
		end else begin
			if (cfg_we) begin
				rep_q <= cfg_wdata;
			end
			if (cmd.load) begin
				n_q   <= n_q + 3'd1;
				pos_q <= '0;
				end_q <= end_of_string;
			end
			if (cmd.scan_step) begin
				unique case (kind)
					SCAN_UNIT, SCAN_PAIR: begin
						pos_q        <= pos_q + adv;
						hold_valid_q <= 1'b1;
					end
					SCAN_DONE: begin
						n_q          <= end_q ? 3'd0 : left;
						pos_q        <= '0;
						hold_valid_q <= 1'b0;
					end
					default: begin
						hold_valid_q <= hold_valid_q;
					end
				endcase
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_q[n_q[1:0]] <= in_byte;
		end
		if (cmd.scan_step) begin
			if (kind == SCAN_DONE) begin
				// Slide the unconsumed tail of the buffer down to the front.
				for (int i = 0; i < 4; i++) begin
					pend_q[i] <= pend_q[pos_q[1:0] + 2'(i)];
				end
			end else begin
				hold_q <= unit;
				lo_q   <= lo_unit;
			end
		end
		if (cmd.pair_lo) begin
			hold_q <= lo_q;
		end
		if (push) begin
			code_q        <= hold_q;
			run_last_q    <= push_last;
			string_last_q <= push_last && end_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign code_unit   = code_q;
	assign run_last    = run_last_q;
	assign string_last = string_last_q;

endmodule

// ----- rtl/u8u16_ctrl.sv -----
// Transcoder controller: sequences byte loads, scan steps and low surrogate emission.
// Depends on u8u16_pkg; talks to u8u16_dp through command and status structs.
module u8u16_ctrl
	import u8u16_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  u8u16_status_t status,
	output u8u16_cmd_t    cmd
);

	u8u16_state_t state_q, state_d;
	logic         stall;

	// A step that must move the held unit out waits until the output register frees up.
	assign stall = status.hold_valid && !status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					unique case (status.kind)
						SCAN_PAIR: state_d = ST_PAIR;
						SCAN_DONE: state_d = ST_IDLE;
						default:   state_d = ST_SCAN;
					endcase
				end
			end
			ST_PAIR: begin
				if (!stall) begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.pair_lo   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: begin
				cmd.scan_step = !stall;
			end
			ST_PAIR: begin
				cmd.pair_lo = !stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 transcoder, top level: one byte beat in, UTF-16 code unit beats out.
// Each byte takes a load step, one scan step per code unit it releases (for a surrogate
// pair a scan step and a pair-low step) and one closing scan step; any step that must
// move a held unit out waits while the output register is full and not being read.
// A decoded unit is held and reaches the output register on the next scan or pair-low
// step, the last unit of a byte on the closing step. Reset empties the buffer, sets '?'.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if, u8u16_ctrl and u8u16_dp.
module utf8_to_utf16_transcoder
	import u8u16_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	u8u16_in_if.sink         bytes,
	u8u16_out_if.source      units,
	input  logic             cfg_we,
	input  logic [UnitW-1:0] cfg_wdata
);

	u8u16_cmd_t    cmd;
	u8u16_status_t status;

	u8u16_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bytes.valid),
		.in_ready (bytes.ready),
		.status   (status),
		.cmd      (cmd)
	);

	u8u16_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_byte       (bytes.in_byte),
		.end_of_string (bytes.end_of_string),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_ready     (units.ready),
		.out_valid     (units.valid),
		.code_unit     (units.code_unit),
		.run_last      (units.run_last),
		.string_last   (units.string_last)
	);

endmodule

// ----- sim/utf8_to_utf16_transcoder_checker.sv -----
`timescale 1ns / 1ps
// Checker for the UTF-8 to UTF-16 transcoder: watches both channels and the config port,
// predicts the code unit beats of each accepted byte beat and compares them in order.
// Depends on u8u16_pkg, u8u16_in_if and u8u16_out_if.
module utf8_to_utf16_transcoder_checker
	import u8u16_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [UnitW-1:0] cfg_wdata,
	u8u16_in_if              bytes,
	u8u16_out_if             units,
	output int               failures,
	output int               outstanding
);

	localparam logic [UnitW-1:0] HighSurrogate = 16'hD800;
	localparam logic [UnitW-1:0] LowSurrogate  = 16'hDC00;
	localparam logic [CpW-1:0]   PlaneOne      = 21'h010000;
	localparam logic [CpW-1:0]   MaxCodePoint  = 21'h10FFFF;
	localparam int               MaxReports    = 100;

	typedef struct packed {
		logic [UnitW-1:0] code_unit;
		logic             run_last;
		logic             string_last;
	} unit_beat_t;

	unit_beat_t       predicted_units[$];
	logic [ByteW-1:0] held_bytes[3];
	int unsigned      held_count;
	logic [UnitW-1:0] replacement;
	int unsigned      beats_seen;

	// Sequence length from the top five bits of a lead byte; zero if it cannot lead.
	function automatic int unsigned sequence_length(input logic [ByteW-1:0] b);
		int unsigned len;
		case (b[7:3]) inside
			[5'd0:5'd15]:  len = 1;
			[5'd24:5'd27]: len = 2;
			[5'd28:5'd29]: len = 3;
			5'd30:         len = 4;
			default:       len = 0;
		endcase
		return len;
	endfunction

	task automatic report_mismatch(input string what, input logic [UnitW-1:0] got,
			input logic [UnitW-1:0] want);
		if (failures < MaxReports)
			$display("mismatch on unit beat %0d: %s got %h expected %h", beats_seen, what, got,
				want);
		failures++;
	endtask

	// Rescans the held bytes plus the new one and queues the units they release.
	task automatic transcode_byte(input logic [ByteW-1:0] b, input logic eos);
		logic [ByteW-1:0] scan[4];
		logic [UnitW-1:0] found[4];
		logic [CpW-1:0]   cp;
		logic [CpW-1:0]   offset;
		int unsigned      n, pos, cnt, need, avail, k;
		logic             bad, stalled;
		unit_beat_t       beat;
		n = 0;
		pos = 0;
		cnt = 0;
		stalled = 1'b0;
		for (k = 0; k < held_count; k++) begin
			scan[n] = held_bytes[k];
			n++;
		end
		scan[n] = b;
		n++;
		while (pos < n && !stalled) begin
			need = sequence_length(scan[pos]);
			if (need == 0) begin
				found[cnt] = replacement;
				cnt++;
				pos++;
			end else if (need == 1) begin
				found[cnt] = {8'h00, scan[pos]};
				cnt++;
				pos++;
			end else begin
				avail = (n - pos < need) ? n - pos : need;
				bad = 1'b0;
				for (k = 1; k < avail; k++)
					if (scan[pos+k][7:6] != 2'b10) bad = 1'b1;
				if (bad || (avail < need && eos)) begin
					// The lead alone is replaced; what follows it is scanned again.
					found[cnt] = replacement;
					cnt++;
					pos++;
				end else if (avail < need) begin
					stalled = 1'b1;
				end else begin
					case (need)
						2: cp = {10'd0, scan[pos][4:0], scan[pos+1][5:0]};
						3: cp = {5'd0, scan[pos][3:0], scan[pos+1][5:0], scan[pos+2][5:0]};
						default: cp = {scan[pos][2:0], scan[pos+1][5:0], scan[pos+2][5:0],
							scan[pos+3][5:0]};
					endcase
					if (cp > MaxCodePoint) begin
						found[cnt] = replacement;
						cnt++;
					end else if (cp >= PlaneOne) begin
						offset = cp - PlaneOne;
						found[cnt] = HighSurrogate + UnitW'(offset[19:10]);
						found[cnt+1] = LowSurrogate + UnitW'(offset[9:0]);
						cnt += 2;
					end else begin
						found[cnt] = cp[UnitW-1:0];
						cnt++;
					end
					pos += need;
				end
			end
		end
		held_count = 0;
		if (!eos) begin
			while (pos < n && held_count < 3) begin
				held_bytes[held_count] = scan[pos];
				held_count++;
				pos++;
			end
		end
		for (k = 0; k < cnt; k++) begin
			beat.code_unit = found[k];
			beat.run_last = (k == cnt - 1);
			beat.string_last = (k == cnt - 1) && eos;
			predicted_units.push_back(beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		unit_beat_t want;
		if (!arst_n) begin
			held_count = 0;
			replacement = ReplacementReset;
			predicted_units.delete();
			failures = 0;
			beats_seen = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) replacement = cfg_wdata;
			if (bytes.valid && bytes.ready) transcode_byte(bytes.in_byte, bytes.end_of_string);
			if (units.valid && units.ready) begin
				if (predicted_units.size() == 0) begin
					report_mismatch("unit with none expected", units.code_unit, '0);
				end else begin
					want = predicted_units.pop_front();
					if (units.code_unit !== want.code_unit)
						report_mismatch("code_unit", units.code_unit, want.code_unit);
					if (units.run_last !== want.run_last)
						report_mismatch("run_last", UnitW'(units.run_last), UnitW'(want.run_last));
					if (units.string_last !== want.string_last)
						report_mismatch("string_last", UnitW'(units.string_last),
							UnitW'(want.string_last));
				end
				beats_seen++;
			end
			outstanding <= predicted_units.size();
		end
	end

endmodule

// ----- sim/utf8_to_utf16_transcoder_tb.sv -----
`timescale 1ns / 1ps
// Top of the transcoder testbench: clock, reset, byte stimulus, sink stalls and verdict.
// Depends on u8u16_pkg, the two channel interfaces, the block and its checker.
module utf8_to_utf16_transcoder_tb;
	import u8u16_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int LongHold    = 300;
	localparam int SettleWait  = 16;
	localparam int PhaseBytes  = 72;
	localparam int RandPhases  = 5;
	localparam int DirectedLen = 24;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [UnitW-1:0] cfg_wdata = '0;
	logic             long_hold_req = 1'b0;
	bit               idle_on = 1'b1;
	int               failures;
	int               outstanding;
	int unsigned      bytes_sent = 0;
	int unsigned      cycle_count = 0;

	// Each entry is {end_of_string, byte}.
	localparam logic [8:0] Directed[DirectedLen] = '{
		9'h000, 9'h07F,                     // ASCII extremes
		9'h0C2, 9'h0A9,                     // two-byte sequence
		9'h0E2, 9'h082, 9'h0AC,             // three-byte sequence
		9'h0F0, 9'h09F, 9'h098, 9'h080,     // surrogate pair
		9'h0F4, 9'h090, 9'h080, 9'h180,     // above the last code point
		9'h0BF, 9'h0FF,                     // stray continuation, invalid lead
		9'h0F0, 9'h080, 9'h080, 9'h041,     // bad continuation, four units
		9'h0F0, 9'h09F, 9'h198              // truncated at end of string
	};

	u8u16_in_if  byte_ch ();
	u8u16_out_if unit_ch ();

	utf8_to_utf16_transcoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.units     (unit_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	utf8_to_utf16_transcoder_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.bytes       (byte_ch),
		.units       (unit_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Sink side: random stall bursts, plus one long hold-off on request.
	initial begin : sink_stalls
		int unsigned n;
		unit_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				unit_ch.ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
				long_hold_req <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				unit_ch.ready <= 1'b0;
				n = $urandom_range(1, 14);
				repeat (n - 1) @(posedge clk);
			end else begin
				unit_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [ByteW-1:0] b, input logic eos);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		byte_ch.end_of_string <= eos;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	// One character: mostly well-formed, sometimes truncated, corrupted or a random byte.
	task automatic send_char(input logic last);
		logic [ByteW-1:0] seq[4];
		logic [CpW-1:0]   cp;
		int unsigned      r, len, cut, i;
		r = $urandom_range(0, 99);
		if (r < 22) begin
			len = 1;
			cp = CpW'($urandom_range(0, 'h7F));
			seq[0] = {1'b0, cp[6:0]};
		end else if (r < 42) begin
			len = 2;
			cp = CpW'($urandom_range(0, 'h7FF));
			seq[0] = {3'b110, cp[10:6]};
		end else if (r < 62) begin
			len = 3;
			cp = CpW'($urandom_range(0, 'hFFFF));
			seq[0] = {4'b1110, cp[15:12]};
		end else begin
			len = 4;
			if ($urandom_range(0, 3) == 0) cp = CpW'($urandom_range(0, 'h1FFFFF));
			else cp = CpW'($urandom_range('h10000, 'h10FFFF));
			seq[0] = {5'b11110, cp[20:18]};
		end
		for (i = 1; i < len; i++)
			seq[i] = {2'b10, 6'((cp >> (6 * (len - 1 - i))) & 'h3F)};
		cut = len;
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 2))
				0: if (len > 1) cut = $urandom_range(1, len - 1);
				1: if (len > 1) seq[$urandom_range(1, len - 1)] = ByteW'($urandom_range(0, 255));
				default: begin
					seq[0] = ByteW'($urandom_range(0, 255));
					cut = 1;
				end
			endcase
		end
		for (i = 0; i < cut; i++) send_byte(seq[i], last && (i == cut - 1));
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
		repeat (SettleWait) @(posedge clk);
	endtask

	task automatic write_replacement(input logic [UnitW-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [UnitW-1:0] settings[RandPhases];
		int unsigned      p, nchars, c, target;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		byte_ch.end_of_string = 1'b0;
		settings[0] = 16'hFFFD;
		settings[1] = 16'h0000;
		settings[2] = 16'hFFFF;
		settings[3] = UnitW'($urandom_range(0, 'hFFFF));
		settings[4] = ReplacementReset;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with the reset replacement unit.
		for (p = 0; p < DirectedLen; p++) send_byte(Directed[p][7:0], Directed[p][8]);

		for (p = 0; p < RandPhases; p++) begin
			byte_ch.valid <= 1'b0;
			wait_drained();
			write_replacement(settings[p]);
			if (p == 1) long_hold_req <= 1'b1;
			if (p == RandPhases - 1) idle_on = 1'b0;
			target = bytes_sent + PhaseBytes;
			while (bytes_sent < target) begin
				nchars = $urandom_range(1, 8);
				for (c = 0; c < nchars; c++) send_char(c == nchars - 1);
			end
		end
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (30) @(posedge clk);
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
